@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL of the stack execute block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/svm_pkg.sv @@
// Package for the stack execute block: payload structs, opcodes, status codes, states.
// Depends on nothing; used by svm_alu and the top level of the block.
package svm_pkg;

   localparam int StackDepthDefault = 256;
   localparam int DataWidth = 64;

   typedef enum logic [4:0] {
      OP_NOP = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
      OP_REM = 5'd5, OP_OR = 5'd6, OP_AND = 5'd7, OP_XOR = 5'd8, OP_SHL = 5'd9,
      OP_SRA = 5'd10, OP_SRL = 5'd11, OP_LT = 5'd12, OP_GT = 5'd13, OP_EQ = 5'd14,
      OP_NOT = 5'd15, OP_NEG = 5'd16, OP_PUSH = 5'd17, OP_POP = 5'd18,
      OP_DUP = 5'd19, OP_SWAP = 5'd20
   } op_type;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_DIV0 = 3'd1;
   localparam logic [2:0] ST_NEGSHIFT = 3'd2;
   localparam logic [2:0] ST_UNDER = 3'd3;
   localparam logic [2:0] ST_OVER = 3'd4;
   localparam logic [2:0] ST_UNKNOWN = 3'd5;

   localparam logic [0:0] REG_TRUE = 1'd0;
   localparam logic [0:0] REG_FALSE = 1'd1;

   typedef struct packed {
      logic [4:0] func;
      logic [63:0] immediate;
   } req_type;

   typedef struct packed {
      logic [63:0] top_value;
      logic top_is_pointer;
      logic [8:0] stack_depth;
      logic [2:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD1, S_RD2, S_LOAD, S_EXEC, S_ITER, S_WR1, S_WR2, S_RDTOP, S_TOP, S_OUT
   } state_type;

   // Controls for the shared unit.
   typedef struct packed {
      logic start;
      logic [4:0] op;
   } alu_ctl_type;

   typedef struct packed {
      logic done;
      logic busy;
   } alu_sts_type;

endpackage

@@ hdl/svm_ram.sv @@
// Generic single-port RAM with registered read.
// Depends on nothing.
module svm_ram #(
   parameter int Width = 64,
   parameter int Depth = 256
) (
   input logic clock,
   input logic we,
   input logic [$clog2(Depth)-1:0] addr,
   input logic [Width-1:0] wdata,
   output logic [Width-1:0] rdata
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

@@ hdl/svm_alu.sv @@
// Shared iterative unit: one add, shift or divide step per cycle over 64 bits.
// Depends on svm_pkg.
module svm_alu (
   input logic clock,
   input logic reset,
   input svm_pkg::alu_ctl_type ctl,
   input logic [63:0] lhs,
   input logic [63:0] rhs,
   output svm_pkg::alu_sts_type sts,
   output logic [63:0] result
);
   logic [63:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] rem_ff, rem_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [4:0] op_ff, op_in;
   logic neg_q_ff, neg_q_in;
   logic neg_r_ff, neg_r_in;
   logic fill_ff, fill_in;
   logic [64:0] diff;
   logic [63:0] rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      op_ff <= op_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      fill_ff <= fill_in;
   end

   assign rem_sh = {rem_ff[62:0], a_ff[63]};
   assign diff = {1'b0, rem_sh} - {1'b0, b_ff};

   always_comb begin
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      fill_in = fill_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in = ctl.op;
         acc_in = 64'd0;
         rem_in = 64'd0;
         cnt_in = 7'd0;
         a_in = lhs;
         b_in = rhs;
         neg_q_in = lhs[63] ^ rhs[63];
         neg_r_in = lhs[63];
         fill_in = (ctl.op == svm_pkg::OP_SRA) && lhs[63];
         if (ctl.op == svm_pkg::OP_DIV || ctl.op == svm_pkg::OP_REM) begin
            a_in = lhs[63] ? (~lhs + 64'd1) : lhs;
            b_in = rhs[63] ? (~rhs + 64'd1) : rhs;
         end
         if (ctl.op == svm_pkg::OP_SHL || ctl.op == svm_pkg::OP_SRA ||
             ctl.op == svm_pkg::OP_SRL) begin
            acc_in = lhs;
            cnt_in = (rhs[63:6] != 58'd0) ? 7'd64 : {1'b0, rhs[5:0]};
         end
         if (ctl.op == svm_pkg::OP_MUL) begin
            cnt_in = 7'd64;
         end
      end else if (busy_ff) begin
         unique case (op_ff)
            svm_pkg::OP_MUL: begin
               if (cnt_ff == 7'd0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  acc_in = (acc_ff << 1) + (a_ff[63] ? b_ff : 64'd0);
                  a_in = a_ff << 1;
                  cnt_in = cnt_ff - 7'd1;
               end
            end
            svm_pkg::OP_DIV, svm_pkg::OP_REM: begin
               if (cnt_ff == 7'd64) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  if (op_ff == svm_pkg::OP_DIV) begin
                     acc_in = neg_q_ff ? (~acc_ff + 64'd1) : acc_ff;
                  end else begin
                     acc_in = neg_r_ff ? (~rem_ff + 64'd1) : rem_ff;
                  end
               end else begin
                  a_in = a_ff << 1;
                  if (!diff[64]) begin
                     rem_in = diff[63:0];
                     acc_in = {acc_ff[62:0], 1'b1};
                  end else begin
                     rem_in = rem_sh;
                     acc_in = {acc_ff[62:0], 1'b0};
                  end
                  cnt_in = cnt_ff + 7'd1;
               end
            end
            svm_pkg::OP_SHL, svm_pkg::OP_SRA, svm_pkg::OP_SRL: begin
               if (cnt_ff == 7'd0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff - 7'd1;
                  if (op_ff == svm_pkg::OP_SHL) begin
                     acc_in = acc_ff << 1;
                  end else begin
                     acc_in = {fill_ff, acc_ff[63:1]};
                  end
               end
            end
            default: begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   assign sts.done = done_ff;
   assign sts.busy = busy_ff;
   assign result = acc_ff;
endmodule

@@ hdl/stack_vm_integer_execute.sv @@
// Top level of the stack execute block: APB registers, sequencer, stack RAMs.
// Depends on svm_pkg, svm_ram, svm_alu and assert_macros.svh.
//
//   Channel | Ports                                     | Direction
//   req     | req_valid, req_stall, req_data            | in
//   rsp     | rsp_valid, rsp_stall, rsp_data            | out
//   csr     | csr_psel, csr_penable, csr_pwrite, csr_paddr | in, 64-bit data
//
// A request passes the states RD1, RD2, LOAD, EXEC, WR1, RDTOP, TOP and OUT before its response
// is valid; pop, nop and failed checks skip WR1, and swap adds WR2. Multiply, divide and shift
// add ITER in the shared unit, which shifts one bit per step for a shift amount of 64 at most.
// The stack RAM has one port. No new request is taken until the response has been accepted.
// Reset empties the stack; entries are not cleared. A stalled response holds the block.
module stack_vm_integer_execute #(
   parameter int STACK_DEPTH = svm_pkg::StackDepthDefault
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input svm_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output svm_pkg::rsp_type rsp_data,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [3:0] csr_paddr,
   input logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   `include "assert_macros.svh"

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int PW = $clog2(STACK_DEPTH + 1);

   svm_pkg::state_type state_ff, state_in;
   logic [PW-1:0] sp_ff, sp_in;
   logic [63:0] true_ff, true_in, false_ff, false_in;
   logic [4:0] op_ff, op_in;
   logic [63:0] imm_ff, imm_in;
   logic [63:0] r_ff, r_in, l_ff, l_in, res_ff, res_in;
   logic rt_ff, rt_in, lt_ff, lt_in, rest_ff, rest_in;
   logic [2:0] st_ff, st_in;
   svm_pkg::rsp_type out_ff, out_in;
   logic outv_ff, outv_in;

   logic we;
   logic [AW-1:0] addr;
   logic [63:0] wval, rval;
   logic wtag, rtag;
   svm_pkg::alu_ctl_type actl;
   svm_pkg::alu_sts_type asts;
   logic [63:0] ares;
   logic [1:0] need;
   logic grows, known;
   logic [PW-1:0] sp_m1, sp_m2;

   svm_ram #(.Width(64), .Depth(STACK_DEPTH)) u_val (
      .clock(clock), .we(we), .addr(addr), .wdata(wval), .rdata(rval));
   svm_ram #(.Width(1), .Depth(STACK_DEPTH)) u_tag (
      .clock(clock), .we(we), .addr(addr), .wdata(wtag), .rdata(rtag));
   svm_alu u_alu (
      .clock(clock), .reset(reset), .ctl(actl), .lhs(l_ff), .rhs(r_ff),
      .sts(asts), .result(ares));

   assign sp_m1 = sp_ff - PW'(1);
   assign sp_m2 = sp_ff - PW'(2);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == svm_pkg::REG_FALSE) ? false_ff : true_ff;
   assign req_stall = (state_ff != svm_pkg::S_IDLE) || outv_ff;
   assign rsp_valid = outv_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svm_pkg::S_IDLE;
         sp_ff <= '0;
         true_ff <= 64'd1;
         false_ff <= 64'd0;
         outv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff <= sp_in;
         true_ff <= true_in;
         false_ff <= false_in;
         outv_ff <= outv_in;
      end
      op_ff <= op_in;
      imm_ff <= imm_in;
      r_ff <= r_in;
      l_ff <= l_in;
      res_ff <= res_in;
      rt_ff <= rt_in;
      lt_ff <= lt_in;
      rest_ff <= rest_in;
      st_ff <= st_in;
      out_ff <= out_in;
   end

   always_comb begin
      true_in = true_ff;
      false_in = false_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2:0] == 3'd0) begin
         if (csr_paddr[3] == svm_pkg::REG_TRUE) begin
            true_in = csr_pwdata;
         end else begin
            false_in = csr_pwdata;
         end
      end
   end

   always_comb begin
      need = 2'd0;
      grows = 1'b0;
      known = 1'b1;
      case (op_ff)
         svm_pkg::OP_NOP: need = 2'd0;
         svm_pkg::OP_NOT, svm_pkg::OP_NEG, svm_pkg::OP_POP: need = 2'd1;
         svm_pkg::OP_PUSH: grows = 1'b1;
         svm_pkg::OP_DUP: begin
            need = 2'd1;
            grows = 1'b1;
         end
         default: begin
            if (op_ff <= svm_pkg::OP_EQ || op_ff == svm_pkg::OP_SWAP) begin
               need = 2'd2;
            end else begin
               known = 1'b0;
            end
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      sp_in = sp_ff;
      op_in = op_ff;
      imm_in = imm_ff;
      r_in = r_ff;
      l_in = l_ff;
      res_in = res_ff;
      rt_in = rt_ff;
      lt_in = lt_ff;
      rest_in = rest_ff;
      st_in = st_ff;
      out_in = out_ff;
      outv_in = outv_ff && rsp_stall;
      we = 1'b0;
      addr = sp_m1[AW-1:0];
      wval = res_ff;
      wtag = rest_ff;
      actl = '0;
      unique case (state_ff)
         svm_pkg::S_IDLE: begin
            if (req_valid && !req_stall) begin
               op_in = req_data.func;
               imm_in = req_data.immediate;
               state_in = svm_pkg::S_RD1;
            end
         end
         svm_pkg::S_RD1: begin
            addr = sp_m1[AW-1:0];
            st_in = svm_pkg::ST_OK;
            if (!known) begin
               st_in = svm_pkg::ST_UNKNOWN;
            end else if (sp_ff < PW'(need)) begin
               st_in = svm_pkg::ST_UNDER;
            end else if (grows && sp_ff >= PW'(STACK_DEPTH)) begin
               st_in = svm_pkg::ST_OVER;
            end
            state_in = svm_pkg::S_RD2;
         end
         svm_pkg::S_RD2: begin
            addr = sp_m2[AW-1:0];
            r_in = rval;
            rt_in = rtag;
            state_in = svm_pkg::S_LOAD;
         end
         svm_pkg::S_LOAD: begin
            l_in = rval;
            lt_in = rtag;
            state_in = svm_pkg::S_EXEC;
         end
         svm_pkg::S_EXEC: begin
            rest_in = 1'b0;
            state_in = svm_pkg::S_RDTOP;
            if (st_ff == svm_pkg::ST_OK) begin
               state_in = svm_pkg::S_WR1;
               case (op_ff)
                  svm_pkg::OP_ADD: res_in = l_ff + r_ff;
                  svm_pkg::OP_SUB: res_in = l_ff - r_ff;
                  svm_pkg::OP_OR: res_in = l_ff | r_ff;
                  svm_pkg::OP_AND: res_in = l_ff & r_ff;
                  svm_pkg::OP_XOR: res_in = l_ff ^ r_ff;
                  svm_pkg::OP_LT: res_in = ($signed(l_ff) < $signed(r_ff)) ? true_ff : false_ff;
                  svm_pkg::OP_GT: res_in = ($signed(r_ff) < $signed(l_ff)) ? true_ff : false_ff;
                  svm_pkg::OP_EQ: res_in = (l_ff == r_ff) ? true_ff : false_ff;
                  svm_pkg::OP_NOT: res_in = ~r_ff;
                  svm_pkg::OP_NEG: res_in = ~r_ff + 64'd1;
                  svm_pkg::OP_PUSH: res_in = imm_ff;
                  svm_pkg::OP_DUP: begin
                     res_in = r_ff;
                     rest_in = rt_ff;
                  end
                  svm_pkg::OP_SWAP: begin
                     res_in = l_ff;
                     rest_in = lt_ff;
                  end
                  svm_pkg::OP_MUL: begin
                     actl.start = 1'b1;
                     actl.op = op_ff;
                     state_in = svm_pkg::S_ITER;
                  end
                  svm_pkg::OP_DIV, svm_pkg::OP_REM: begin
                     if (r_ff == 64'd0) begin
                        st_in = svm_pkg::ST_DIV0;
                        state_in = svm_pkg::S_RDTOP;
                     end else begin
                        actl.start = 1'b1;
                        actl.op = op_ff;
                        state_in = svm_pkg::S_ITER;
                     end
                  end
                  svm_pkg::OP_SHL, svm_pkg::OP_SRA, svm_pkg::OP_SRL: begin
                     if (r_ff[63]) begin
                        st_in = svm_pkg::ST_NEGSHIFT;
                        state_in = svm_pkg::S_RDTOP;
                     end else begin
                        actl.start = 1'b1;
                        actl.op = op_ff;
                        state_in = svm_pkg::S_ITER;
                     end
                  end
                  svm_pkg::OP_POP: begin
                     sp_in = sp_m1;
                     state_in = svm_pkg::S_RDTOP;
                  end
                  default: state_in = svm_pkg::S_RDTOP;
               endcase
            end
         end
         svm_pkg::S_ITER: begin
            if (asts.done) begin
               res_in = ares;
               state_in = svm_pkg::S_WR1;
            end
         end
         svm_pkg::S_WR1: begin
            we = 1'b1;
            if (op_ff == svm_pkg::OP_PUSH || op_ff == svm_pkg::OP_DUP) begin
               addr = sp_ff[AW-1:0];
               sp_in = sp_ff + PW'(1);
               state_in = svm_pkg::S_RDTOP;
            end else if (op_ff == svm_pkg::OP_NOT || op_ff == svm_pkg::OP_NEG) begin
               addr = sp_m1[AW-1:0];
               state_in = svm_pkg::S_RDTOP;
            end else if (op_ff == svm_pkg::OP_SWAP) begin
               addr = sp_m2[AW-1:0];
               wval = r_ff;
               wtag = rt_ff;
               state_in = svm_pkg::S_WR2;
            end else begin
               addr = sp_m2[AW-1:0];
               sp_in = sp_m1;
               state_in = svm_pkg::S_RDTOP;
            end
         end
         svm_pkg::S_WR2: begin
            we = 1'b1;
            addr = sp_m1[AW-1:0];
            state_in = svm_pkg::S_RDTOP;
         end
         svm_pkg::S_RDTOP: begin
            addr = sp_m1[AW-1:0];
            state_in = svm_pkg::S_TOP;
         end
         svm_pkg::S_TOP: begin
            out_in.top_value = (sp_ff != '0) ? rval : 64'd0;
            out_in.top_is_pointer = (sp_ff != '0) ? rtag : 1'b0;
            out_in.stack_depth = 9'(sp_ff);
            out_in.status = st_ff;
            state_in = svm_pkg::S_OUT;
         end
         svm_pkg::S_OUT: begin
            if (!outv_ff) begin
               outv_in = 1'b1;
               state_in = svm_pkg::S_IDLE;
            end
         end
         default: state_in = svm_pkg::S_IDLE;
      endcase
   end

   `ASSERT_IMPL(a_sp_range, clock, reset, 1'b1, sp_ff <= PW'(STACK_DEPTH), "stack pointer beyond depth")
   `ASSERT_NEXT(a_fail_keeps_sp, clock, reset, state_ff == svm_pkg::S_EXEC && st_ff != svm_pkg::ST_OK, $stable(sp_ff), "failed request moved the stack")
   `ASSERT_IMPL(a_alu_only_iter, clock, reset, asts.busy, state_ff == svm_pkg::S_ITER, "shared unit busy outside iteration")
endmodule
